@@ design/tlj_pkg.sv @@
// Shared types, constants and arithmetic helpers of the two-link joint torque block.
`default_nettype none

package tlj_pkg;

  localparam int unsigned TrigTableBitsDef = 10;
  localparam int unsigned CfgAddrW         = 5;
  localparam logic [63:0] HalfPiQ30        = 64'd1686629713;
  localparam int unsigned TermDiv [7]      = '{6, 20, 42, 72, 110, 156, 210};

  typedef struct packed {
    logic signed [15:0] hip_angle;
    logic signed [15:0] hip_velocity;
    logic signed [15:0] hip_accel;
    logic signed [15:0] knee_angle;
    logic signed [15:0] knee_velocity;
    logic signed [15:0] knee_accel;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] hip_total;
    logic signed [31:0] knee_total;
    logic signed [31:0] hip_inertial;
    logic signed [31:0] hip_coriolis;
    logic signed [31:0] hip_gravity;
    logic signed [31:0] knee_inertial;
    logic signed [31:0] knee_coriolis;
    logic signed [31:0] knee_gravity;
  } out_item_t;

  typedef struct packed {
    logic [15:0] thigh_mass;
    logic [15:0] shank_mass;
    logic [15:0] thigh_com_dist;
    logic [15:0] shank_com_dist;
    logic [15:0] thigh_length;
    logic [15:0] thigh_inertia;
    logic [15:0] shank_inertia;
    logic [15:0] gravity_accel;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    thigh_mass:     16'd0,
    shank_mass:     16'd0,
    thigh_com_dist: 16'd0,
    shank_com_dist: 16'd0,
    thigh_length:   16'd0,
    thigh_inertia:  16'd0,
    shank_inertia:  16'd0,
    gravity_accel:  16'd2511
  };

  // Quarter-wave sine entry in unsigned Q1.14, evaluated at elaboration only.
  function automatic logic [14:0] sine_entry(int unsigned k, int unsigned tb);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    x    = (64'(k) * HalfPiQ30) >> tb;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'(TermDiv[n-1]);
      if ((n & 1) != 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    v = (sum > 64'sd0) ? 64'((sum + 64'sd32768) >>> 16) : 64'd0;
    if (v > 64'd16384) begin
      v = 64'd16384;
    end
    return 15'(v);
  endfunction

  // Round to nearest, ties away from zero, then drop s fraction bits.
  function automatic logic signed [63:0] rnd(logic signed [63:0] v, int unsigned s);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/tlj_if.sv @@
// Valid/ready channel interfaces for joint samples and torque results.
`default_nettype none

interface tlj_in_if;
  logic                valid;
  logic                ready;
  tlj_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tlj_out_if;
  logic                valid;
  logic                ready;
  tlj_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/tlj_cfg.sv @@
// APB register bank holding the link masses, lengths, inertias and gravity.
`default_nettype none

module tlj_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlj_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output tlj_pkg::cfg_t                 cfg_o
);

  typedef enum logic [2:0] {
    RegThighMass,
    RegShankMass,
    RegThighCom,
    RegShankCom,
    RegThighLen,
    RegThighInertia,
    RegShankInertia,
    RegGravity
  } reg_idx_e;

  tlj_pkg::cfg_t cfg_q, cfg_d;
  reg_idx_e      idx;
  logic [15:0]   rd_val;

  assign idx    = reg_idx_e'(paddr[tlj_pkg::CfgAddrW-1:2]);
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (idx)
        RegThighMass:    cfg_d.thigh_mass     = pwdata[15:0];
        RegShankMass:    cfg_d.shank_mass     = pwdata[15:0];
        RegThighCom:     cfg_d.thigh_com_dist = pwdata[15:0];
        RegShankCom:     cfg_d.shank_com_dist = pwdata[15:0];
        RegThighLen:     cfg_d.thigh_length   = pwdata[15:0];
        RegThighInertia: cfg_d.thigh_inertia  = pwdata[15:0];
        RegShankInertia: cfg_d.shank_inertia  = pwdata[15:0];
        RegGravity:      cfg_d.gravity_accel  = pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegThighMass:    rd_val = cfg_q.thigh_mass;
      RegShankMass:    rd_val = cfg_q.shank_mass;
      RegThighCom:     rd_val = cfg_q.thigh_com_dist;
      RegShankCom:     rd_val = cfg_q.shank_com_dist;
      RegThighLen:     rd_val = cfg_q.thigh_length;
      RegThighInertia: rd_val = cfg_q.thigh_inertia;
      RegShankInertia: rd_val = cfg_q.shank_inertia;
      RegGravity:      rd_val = cfg_q.gravity_accel;
    endcase
  end

  assign prdata = {16'd0, rd_val};
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tlj_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

@@ design/tlj_sine.sv @@
// Quarter-wave sine ROM with registered read and quadrant folding.
`default_nettype none

module tlj_sine #(
  parameter int unsigned TrigTableBits = tlj_pkg::TrigTableBitsDef
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [15:0]        angle_i,
  output logic signed [15:0] sine_o
);

  localparam int unsigned TabN = 1 << TrigTableBits;

  logic [14:0]              tab [TabN+1];
  logic [1:0]               quad;
  logic [TrigTableBits-1:0] idx;
  logic [TrigTableBits:0]   pos;
  logic [14:0]              mag_q;
  logic                     neg_q;

  for (genvar k = 0; k < TabN + 1; k++) begin : g_tab
    assign tab[k] = tlj_pkg::sine_entry(k, TrigTableBits);
  end

  assign quad = angle_i[15:14];
  assign idx  = angle_i[13 -: TrigTableBits];
  // mirror the index in the odd quadrants
  assign pos  = quad[0] ? ((TrigTableBits+1)'(TabN) - {1'b0, idx}) : {1'b0, idx};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= tab[pos];
      neg_q <= quad[1];
    end
  end

  assign sine_o = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule

`default_nettype wire

@@ design/tlj_pipe.sv @@
// Ten-stage inverse dynamics datapath: trig, inertia, Coriolis and gravity terms.
`default_nettype none

module tlj_pipe #(
  parameter int unsigned TrigTableBits = tlj_pkg::TrigTableBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tlj_pkg::cfg_t cfg_i,
  tlj_in_if.sink        in_i,
  tlj_out_if.source     out_o
);

  localparam int unsigned NumStages = 10;

  logic [NumStages-1:0] vld_q, vld_d, rdy;

  logic [15:0] m1, m2, r1, r2, l1, i1, i2, g;
  logic [15:0] ang12;
  logic signed [15:0] c1, c2, s2, c12;

  // stage 0
  logic signed [15:0] v1_q [7];
  logic signed [15:0] v2_q [7];
  logic signed [15:0] a1_q [5];
  logic signed [15:0] a2_q [5];
  logic signed [16:0] vs_q [5];
  logic [31:0] plr_q, m2r2_q, m1r1_q, m2l1_q;
  logic [31:0] mg1_0_q, mg2_0_q;
  // stage 1
  logic signed [47:0] lc2p_q, ls2p_q, lc2p_d, ls2p_d;
  logic [47:0] m2r2sq_q, m1r1sq_q, m2l1sq_q, m2r2sq_d, m1r1sq_d, m2l1sq_d;
  logic signed [31:0] r1c1_q, l1c1_q, r2c12_q, r1c1_d, l1c1_d, r2c12_d;
  logic [31:0] mg1_1_q, mg2_1_q;
  // stage 2
  logic signed [33:0] lc2_q, ls2_q, lc2_d, ls2_d;
  logic signed [63:0] gp1_q, gp2_q, gp3_q, gp1_d, gp2_d, gp3_d;
  logic [49:0] mb00_2_q, mb00_d;
  logic [48:0] mb01_2_q, mb01_d;
  logic [29:0] mm11_2_q, mm11_d;
  // stage 3
  logic signed [50:0] m2lc2_q, m2ls2_q, m2lc2_d, m2ls2_d;
  logic signed [35:0] g1_q, g2_q, g3_q, g1_d, g2_d, g3_d;
  logic [49:0] mb00_3_q;
  logic [48:0] mb01_3_q;
  logic [29:0] mm11_3_q;
  // stage 4
  logic signed [63:0] sum00, sum01;
  logic signed [33:0] mm00_q, mm01_q, mm00_d, mm01_d;
  logic signed [29:0] t_q, t_d;
  logic signed [37:0] hgr_q [5];
  logic signed [37:0] hgr_d;
  logic signed [35:0] kgr_q [5];
  logic [29:0] mm11_4_q;
  // stage 5
  logic signed [49:0] p00_q, p01_q, p10_q, p11_q, p00_d, p01_d, p10_d, p11_d;
  logic signed [45:0] tv1_q, tv2_q, tv1_d, tv2_d;
  logic signed [46:0] tvs_q, tvs_d;
  // stage 6
  logic signed [42:0] hin_q [3];
  logic signed [42:0] kin_q [3];
  logic signed [42:0] hin_d, kin_d;
  logic signed [39:0] cc00_q, cc01_q, cc10_q, cc00_d, cc01_d, cc10_d;
  // stage 7
  logic signed [55:0] q00_q, q01_q, q10_q, q00_d, q01_d, q10_d;
  // stage 8
  logic signed [48:0] hco_q, kco_q, hco_d, kco_d;
  // stage 9
  tlj_pkg::out_item_t res_q, res_d;

  assign m1 = cfg_i.thigh_mass;
  assign m2 = cfg_i.shank_mass;
  assign r1 = cfg_i.thigh_com_dist;
  assign r2 = cfg_i.shank_com_dist;
  assign l1 = cfg_i.thigh_length;
  assign i1 = cfg_i.thigh_inertia;
  assign i2 = cfg_i.shank_inertia;
  assign g  = cfg_i.gravity_accel;

  // a stage takes a new request when empty or when its successor moves on
  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || out_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) begin
      vld_d[0] = in_i.valid;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready  = rdy[0];
  assign out_o.valid = vld_q[NumStages-1];
  assign out_o.data  = res_q;

  // stage 0: sine ROM reads
  assign ang12 = 16'(in_i.data.hip_angle) + 16'(in_i.data.knee_angle);

  tlj_sine #(.TrigTableBits(TrigTableBits)) u_cos_hip (
    .clk_i(clk_i), .en_i(rdy[0]),
    .angle_i(16'(in_i.data.hip_angle) + 16'h4000), .sine_o(c1)
  );
  tlj_sine #(.TrigTableBits(TrigTableBits)) u_cos_knee (
    .clk_i(clk_i), .en_i(rdy[0]),
    .angle_i(16'(in_i.data.knee_angle) + 16'h4000), .sine_o(c2)
  );
  tlj_sine #(.TrigTableBits(TrigTableBits)) u_sin_knee (
    .clk_i(clk_i), .en_i(rdy[0]),
    .angle_i(16'(in_i.data.knee_angle)), .sine_o(s2)
  );
  tlj_sine #(.TrigTableBits(TrigTableBits)) u_cos_sum (
    .clk_i(clk_i), .en_i(rdy[0]),
    .angle_i(ang12 + 16'h4000), .sine_o(c12)
  );

  always_comb begin
    // stage 1
    lc2p_d   = 48'($signed({1'b0, plr_q})) * 48'(c2);
    ls2p_d   = 48'($signed({1'b0, plr_q})) * 48'(s2);
    m2r2sq_d = 48'(m2r2_q) * 48'(r2);
    m1r1sq_d = 48'(m1r1_q) * 48'(r1);
    m2l1sq_d = 48'(m2l1_q) * 48'(l1);
    r1c1_d   = 32'($signed({1'b0, r1})) * 32'(c1);
    l1c1_d   = 32'($signed({1'b0, l1})) * 32'(c1);
    r2c12_d  = 32'($signed({1'b0, r2})) * 32'(c12);
    // stage 2
    lc2_d  = 34'(tlj_pkg::rnd(64'(lc2p_q), 14));
    ls2_d  = 34'(tlj_pkg::rnd(64'(ls2p_q), 14));
    gp1_d  = 64'($signed({1'b0, mg1_1_q})) * 64'(r1c1_q);
    gp2_d  = 64'($signed({1'b0, mg2_1_q})) * 64'(l1c1_q);
    gp3_d  = 64'($signed({1'b0, mg2_1_q})) * 64'(r2c12_q);
    mb00_d = 50'(m1r1sq_q) + 50'(m2l1sq_q) + 50'(m2r2sq_q) + 50'({i1, 24'd0});
    mb01_d = 49'(m2r2sq_q) + 49'({i1, 24'd0});
    mm11_d = 30'((49'(m2r2sq_q) + 49'({i2, 24'd0}) + (49'd1 << 19)) >> 20);
    // stage 3
    m2lc2_d = 51'($signed({1'b0, m2})) * 51'(lc2_q);
    m2ls2_d = 51'($signed({1'b0, m2})) * 51'(ls2_q);
    g1_d    = 36'(tlj_pkg::rnd(gp1_q, 28));
    g2_d    = 36'(tlj_pkg::rnd(gp2_q, 28));
    g3_d    = 36'(tlj_pkg::rnd(gp3_q, 28));
    // stage 4
    sum00  = $signed({14'd0, mb00_3_q}) + (64'(m2lc2_q) <<< 1);
    sum01  = $signed({15'd0, mb01_3_q}) + 64'(m2lc2_q);
    mm00_d = 34'(tlj_pkg::rnd(sum00, 20));
    mm01_d = 34'(tlj_pkg::rnd(sum01, 20));
    t_d    = 30'(tlj_pkg::rnd(64'(m2ls2_q), 20));
    hgr_d  = 38'(g1_q) + 38'(g2_q) + 38'(g3_q);
    // stage 5
    p00_d = 50'(mm00_q) * 50'(a1_q[4]);
    p01_d = 50'(mm01_q) * 50'(a2_q[4]);
    p10_d = 50'(mm01_q) * 50'(a1_q[4]);
    p11_d = 50'($signed({1'b0, mm11_4_q})) * 50'(a2_q[4]);
    tv1_d = 46'(t_q) * 46'(v1_q[4]);
    tv2_d = 46'(t_q) * 46'(v2_q[4]);
    tvs_d = 47'(t_q) * 47'(vs_q[4]);
    // stage 6
    hin_d  = 43'(tlj_pkg::rnd(64'(p00_q) + 64'(p01_q), 8));
    kin_d  = 43'(tlj_pkg::rnd(64'(p10_q) + 64'(p11_q), 8));
    cc00_d = -40'(tlj_pkg::rnd(64'(tv2_q), 8));
    cc01_d = -40'(tlj_pkg::rnd(64'(tvs_q), 8));
    cc10_d = 40'(tlj_pkg::rnd(64'(tv1_q), 8));
    // stage 7
    q00_d = 56'(cc00_q) * 56'(v1_q[6]);
    q01_d = 56'(cc01_q) * 56'(v2_q[6]);
    q10_d = 56'(cc10_q) * 56'(v1_q[6]);
    // stage 8
    hco_d = 49'(tlj_pkg::rnd(64'(q00_q) + 64'(q01_q), 8));
    kco_d = 49'(tlj_pkg::rnd(64'(q10_q), 8));
    // stage 9: totals take the unclamped parts, then clamp
    res_d.hip_total     = tlj_pkg::sat32(64'(hin_q[2]) + 64'(hco_q));
    res_d.knee_total    = tlj_pkg::sat32(64'(kin_q[2]) + 64'(kco_q));
    res_d.hip_inertial  = tlj_pkg::sat32(64'(hin_q[2]));
    res_d.hip_coriolis  = tlj_pkg::sat32(64'(hco_q));
    res_d.hip_gravity   = tlj_pkg::sat32(64'(hgr_q[4]));
    res_d.knee_inertial = tlj_pkg::sat32(64'(kin_q[2]));
    res_d.knee_coriolis = tlj_pkg::sat32(64'(kco_q));
    res_d.knee_gravity  = tlj_pkg::sat32(64'(kgr_q[4]));
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      v1_q[0] <= in_i.data.hip_velocity;
      v2_q[0] <= in_i.data.knee_velocity;
      a1_q[0] <= in_i.data.hip_accel;
      a2_q[0] <= in_i.data.knee_accel;
      vs_q[0] <= 17'(in_i.data.hip_velocity) + 17'(in_i.data.knee_velocity);
      plr_q   <= 32'(l1) * 32'(r2);
      m2r2_q  <= 32'(m2) * 32'(r2);
      m1r1_q  <= 32'(m1) * 32'(r1);
      m2l1_q  <= 32'(m2) * 32'(l1);
      mg1_0_q <= 32'(m1) * 32'(g);
      mg2_0_q <= 32'(m2) * 32'(g);
    end
    for (int k = 1; k < 7; k++) begin
      if (rdy[k]) begin
        v1_q[k] <= v1_q[k-1];
        v2_q[k] <= v2_q[k-1];
      end
    end
    for (int k = 1; k < 5; k++) begin
      if (rdy[k]) begin
        a1_q[k] <= a1_q[k-1];
        a2_q[k] <= a2_q[k-1];
        vs_q[k] <= vs_q[k-1];
      end
    end
    if (rdy[1]) begin
      lc2p_q   <= lc2p_d;
      ls2p_q   <= ls2p_d;
      m2r2sq_q <= m2r2sq_d;
      m1r1sq_q <= m1r1sq_d;
      m2l1sq_q <= m2l1sq_d;
      r1c1_q   <= r1c1_d;
      l1c1_q   <= l1c1_d;
      r2c12_q  <= r2c12_d;
      mg1_1_q  <= mg1_0_q;
      mg2_1_q  <= mg2_0_q;
    end
    if (rdy[2]) begin
      lc2_q    <= lc2_d;
      ls2_q    <= ls2_d;
      gp1_q    <= gp1_d;
      gp2_q    <= gp2_d;
      gp3_q    <= gp3_d;
      mb00_2_q <= mb00_d;
      mb01_2_q <= mb01_d;
      mm11_2_q <= mm11_d;
    end
    if (rdy[3]) begin
      m2lc2_q  <= m2lc2_d;
      m2ls2_q  <= m2ls2_d;
      g1_q     <= g1_d;
      g2_q     <= g2_d;
      g3_q     <= g3_d;
      mb00_3_q <= mb00_2_q;
      mb01_3_q <= mb01_2_q;
      mm11_3_q <= mm11_2_q;
    end
    if (rdy[4]) begin
      mm00_q   <= mm00_d;
      mm01_q   <= mm01_d;
      t_q      <= t_d;
      hgr_q[0] <= hgr_d;
      kgr_q[0] <= g3_q;
      mm11_4_q <= mm11_3_q;
    end
    for (int k = 1; k < 5; k++) begin
      if (rdy[k+4]) begin
        hgr_q[k] <= hgr_q[k-1];
        kgr_q[k] <= kgr_q[k-1];
      end
    end
    if (rdy[5]) begin
      p00_q <= p00_d;
      p01_q <= p01_d;
      p10_q <= p10_d;
      p11_q <= p11_d;
      tv1_q <= tv1_d;
      tv2_q <= tv2_d;
      tvs_q <= tvs_d;
    end
    if (rdy[6]) begin
      hin_q[0] <= hin_d;
      kin_q[0] <= kin_d;
      cc00_q   <= cc00_d;
      cc01_q   <= cc01_d;
      cc10_q   <= cc10_d;
    end
    for (int k = 1; k < 3; k++) begin
      if (rdy[k+6]) begin
        hin_q[k] <= hin_q[k-1];
        kin_q[k] <= kin_q[k-1];
      end
    end
    if (rdy[7]) begin
      q00_q <= q00_d;
      q01_q <= q01_d;
      q10_q <= q10_d;
    end
    if (rdy[8]) begin
      hco_q <= hco_d;
      kco_q <= kco_d;
    end
    if (rdy[9]) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

@@ design/two_link_joint_torque.sv @@
// Top level of the two-link hip/knee inverse dynamics torque block.
//
//   channel   direction  handshake       payload
//   in_i      sink       valid / ready   joint angles, velocities, accelerations
//   out_o     source     valid / ready   inertial, Coriolis, gravity, total torques
//   apb       slave      psel / penable  eight 16-bit link parameters at 4*i
//
// A result appears on out_o after its request has passed through the ten pipeline
// stages. One request is taken per cycle unless backpressure from out_o has
// filled the pipeline back to in_i.
// Reset clears the valid bits and loads the register defaults.
// A stalled output holds its result; each stage still fills while empty,
// so the pipeline compacts before backpressure reaches in_i.
`default_nettype none

module two_link_joint_torque #(
  parameter int unsigned TrigTableBits = tlj_pkg::TrigTableBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tlj_in_if.sink                        in_i,
  tlj_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlj_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  tlj_pkg::cfg_t cfg;

  tlj_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tlj_pipe #(.TrigTableBits(TrigTableBits)) u_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

`ifndef SYNTHESIS
  a_ready_follows_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready) else $error("input stalled with output ready");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready) else $error("input stalled with output empty");

  a_reg_readback : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && rst_ni) ##1 (paddr == $past(paddr))
    |-> prdata == {16'd0, $past(pwdata[15:0])}) else $error("register readback mismatch");
`endif

endmodule

`default_nettype wire
